[src/ctgu_pkg.sv]
// shared types and constants for the clifford tableau gate update core
// lane width, stream widths, gate codes and the word structs used by the core and its checker
// no dependencies
`default_nettype none

package ctgu_pkg;

    // tableau rows handled per word
    localparam int LANE_BITS = 64;

    // gate selector width on tuser
    localparam int GATE_BITS = 5;

    // stream payload sizes, padded up to whole bytes
    localparam int IN_FIELD_BITS  = 5 * LANE_BITS;
    localparam int OUT_FIELD_BITS = 4 * LANE_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef logic [LANE_BITS-1:0] t_lane;

    // gate codes; fused names apply the rightmost gate first
    typedef enum logic [GATE_BITS-1:0] {
        GATE_I    = 5'd0,
        GATE_H    = 5'd1,
        GATE_S    = 5'd2,
        GATE_Z    = 5'd3,
        GATE_R    = 5'd4,
        GATE_X    = 5'd5,
        GATE_Y    = 5'd6,
        GATE_HX   = 5'd7,
        GATE_SX   = 5'd8,
        GATE_RX   = 5'd9,
        GATE_HZ   = 5'd10,
        GATE_HY   = 5'd11,
        GATE_SH   = 5'd12,
        GATE_RH   = 5'd13,
        GATE_HS   = 5'd14,
        GATE_HR   = 5'd15,
        GATE_HSX  = 5'd16,
        GATE_HRX  = 5'd17,
        GATE_SHY  = 5'd18,
        GATE_RHY  = 5'd19,
        GATE_HSH  = 5'd20,
        GATE_HRH  = 5'd21,
        GATE_RHS  = 5'd22,
        GATE_SHR  = 5'd23,
        GATE_CNOT = 5'd24,
        GATE_CZ   = 5'd25
    } t_gate_code;

    // one input word: gate plus the five tableau column slices
    typedef struct packed {
        t_gate_code gate;
        t_lane      tx;
        t_lane      tz;
        t_lane      cx;
        t_lane      cz;
        t_lane      ph;
    } t_gate_in;

    // one result word
    typedef struct packed {
        t_lane tx;
        t_lane tz;
        t_lane cz;
        t_lane ph;
    } t_gate_out;

endpackage

`default_nettype wire

[src/ctgu_update.sv]
// per-row clifford gate update of one tableau word, pure combinational
// depends on ctgu_pkg for the gate codes and word structs
`default_nettype none

module ctgu_update
    import ctgu_pkg::*;
(
    input  t_gate_in  i_word,
    output t_gate_out o_word
);

    t_lane x, z, cx, cz, r;

    assign x  = i_word.tx;
    assign z  = i_word.tz;
    assign cx = i_word.cx;
    assign cz = i_word.cz;
    assign r  = i_word.ph;

    // gate decode, every row bit handled on its own
    always_comb begin
        o_word.tx = x;
        o_word.tz = z;
        o_word.cz = cz;
        o_word.ph = r;
        case (i_word.gate)
            GATE_I: begin
            end
            GATE_H: begin
                o_word.tx = z;      o_word.tz = x;      o_word.ph = r ^ (x & z);
            end
            GATE_S: begin
                o_word.tz = x ^ z;  o_word.ph = r ^ (x & z);
            end
            GATE_Z: begin
                o_word.ph = r ^ x;
            end
            GATE_R: begin
                o_word.tz = x ^ z;  o_word.ph = r ^ (x & ~z);
            end
            GATE_X: begin
                o_word.ph = r ^ z;
            end
            GATE_Y: begin
                o_word.ph = r ^ x ^ z;
            end
            GATE_HX: begin
                o_word.tx = z;      o_word.tz = x;      o_word.ph = r ^ (~x & z);
            end
            GATE_SX: begin
                o_word.tz = x ^ z;  o_word.ph = r ^ (~x & z);
            end
            GATE_RX: begin
                o_word.tz = x ^ z;  o_word.ph = r ^ (x | z);
            end
            GATE_HZ: begin
                o_word.tx = z;      o_word.tz = x;      o_word.ph = r ^ (x & ~z);
            end
            // phase flips on x or z here
            GATE_HY: begin
                o_word.tx = z;      o_word.tz = x;      o_word.ph = r ^ (x | z);
            end
            GATE_SH: begin
                o_word.tx = z;      o_word.tz = x ^ z;
            end
            GATE_RH: begin
                o_word.tx = z;      o_word.tz = x ^ z;  o_word.ph = r ^ z;
            end
            GATE_HS: begin
                o_word.tx = x ^ z;  o_word.tz = x;      o_word.ph = r ^ x;
            end
            GATE_HR: begin
                o_word.tx = x ^ z;  o_word.tz = x;
            end
            GATE_HSX: begin
                o_word.tx = x ^ z;  o_word.tz = x;      o_word.ph = r ^ x ^ z;
            end
            GATE_HRX: begin
                o_word.tx = x ^ z;  o_word.tz = x;      o_word.ph = r ^ z;
            end
            GATE_SHY: begin
                o_word.tx = z;      o_word.tz = x ^ z;  o_word.ph = r ^ x ^ z;
            end
            GATE_RHY: begin
                o_word.tx = z;      o_word.tz = x ^ z;  o_word.ph = r ^ x;
            end
            GATE_HSH: begin
                o_word.tx = x ^ z;  o_word.ph = r ^ (~x & z);
            end
            GATE_HRH: begin
                o_word.tx = x ^ z;  o_word.ph = r ^ (x & z);
            end
            GATE_RHS: begin
                o_word.tx = x ^ z;  o_word.ph = r ^ (x | z);
            end
            GATE_SHR: begin
                o_word.tx = x ^ z;  o_word.ph = r ^ (x & ~z);
            end
            // control drives x onto the target, target z back onto the control
            GATE_CNOT: begin
                o_word.ph = r ^ (cx & z & ~(x ^ cz));
                o_word.tx = x ^ cx;
                o_word.cz = cz ^ z;
            end
            GATE_CZ: begin
                o_word.ph = r ^ (cx & x & (cz ^ z));
                o_word.tz = z ^ cx;
                o_word.cz = cz ^ x;
            end
            // unused codes pass the word through
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[src/clifford_tableau_gate_update_core.sv]
// an accepted input word is registered in the input stage, passes the gate logic and is
// registered again in the result stage before it shows as a valid result word
// throughput: one word per cycle while the result side does not stall, set by the input and result register stages
// backpressure on the result side holds both stages; ready chains back through them
// reset (synchronous, active low) clears only the two stage valid flags
// top level of the clifford tableau gate update core
// depends on ctgu_pkg and ctgu_update
`default_nettype none

module clifford_tableau_gate_update_core
    import ctgu_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input stream
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata from bit 0: target_x_word, target_z_word, control_x_word,
    // control_z_word, phase_word
    input  wire logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    // tuser: gate_code
    input  wire logic [GATE_BITS-1:0]      i_s_axis_tuser,
    // result stream
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // tdata from bit 0: new_target_x, new_target_z, new_control_z, new_phase
    output logic [OUT_TDATA_BITS-1:0]      o_m_axis_tdata
);

    logic      r_in_valid;
    t_gate_in  r_in;
    t_gate_in  n_in;
    logic      r_out_valid;
    t_gate_out r_out;
    t_gate_out w_result;
    logic      w_in_load;
    logic      w_out_load;

    // stage advance: a stage loads when it is empty or its content moves on
    assign w_out_load      = !r_out_valid || i_m_axis_tready;
    assign w_in_load       = !r_in_valid || w_out_load;
    assign o_s_axis_tready = w_in_load;

    // unpack the incoming word
    always_comb begin
        n_in.gate = t_gate_code'(i_s_axis_tuser);
        n_in.tx   = i_s_axis_tdata[0*LANE_BITS +: LANE_BITS];
        n_in.tz   = i_s_axis_tdata[1*LANE_BITS +: LANE_BITS];
        n_in.cx   = i_s_axis_tdata[2*LANE_BITS +: LANE_BITS];
        n_in.cz   = i_s_axis_tdata[3*LANE_BITS +: LANE_BITS];
        n_in.ph   = i_s_axis_tdata[4*LANE_BITS +: LANE_BITS];
    end

    // input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_s_axis_tvalid) begin
            r_in <= n_in;
        end
    end

    // gate logic between the two stages
    ctgu_update u_update (
        .i_word (r_in),
        .o_word (w_result)
    );

    // result register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_in_valid) begin
            r_out <= w_result;
        end
    end

    // pack the result word, zero fill to the byte boundary
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_BITS'({r_out.ph, r_out.cz, r_out.tz, r_out.tx});

endmodule

`default_nettype wire

[src/ctgu_checker.sv]
// port-level checks for the clifford tableau gate update core, bound to the top level
// depends on ctgu_pkg for the stream widths
`default_nettype none

module ctgu_checker
    import ctgu_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_axis_tvalid,
    input wire logic                      o_s_axis_tready,
    input wire logic                      o_m_axis_tvalid,
    input wire logic                      i_m_axis_tready,
    input wire logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    // reset empties the result stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result word changed");

    // input side only stalls when both stages are full and the output is stalled
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled with room in the pipeline");

    // a fresh result needs a word accepted on the input side that has passed the input stage
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready, 2))
        else $error("result word without an accepted input word");

endmodule

bind clifford_tableau_gate_update_core ctgu_checker u_ctgu_checker (.*);

`default_nettype wire
